### design/pvd_pkg.sv
`timescale 1ns / 1ps

package pvd_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned ValueW  = 64;
  localparam int unsigned LenW    = 4;

  // Lead-one counts of 7 and 8 (first byte 0xFE or 0xFF) announce a full
  // 8-byte big-endian value after the prefix byte.
  localparam logic [LenW-1:0] LeadFull   = 4'd7;
  localparam logic [LenW-1:0] LenFull    = 4'd9;
  localparam logic [LenW-1:0] FullBytes  = 4'd8;
  localparam logic [LenW-1:0] LenMax     = 4'd9;

  typedef struct packed {
    logic [LenW-1:0]   bytes_left;
    logic [LenW-1:0]   total_length;
    logic [ValueW-1:0] accum;
  } pvd_state_t;

  typedef struct packed {
    logic              done;
    logic [ValueW-1:0] value;
    logic [LenW-1:0]   length;
  } pvd_result_t;

  // Number of leading one bits of a byte, 0 to 8.
  function automatic logic [LenW-1:0] lead_ones(input logic [ByteW-1:0] b);
    logic [LenW-1:0] n;
    logic            run;
    n   = '0;
    run = 1'b1;
    for (int i = ByteW - 1; i >= 0; i--) begin
      run = run & b[i];
      n   = n + LenW'(run);
    end
    return n;
  endfunction

  // Sign extension of a 7*L-bit payload for L from 1 to 7; longer codes
  // already fill the word.
  function automatic logic [ValueW-1:0] sign_fix(input logic [ValueW-1:0] a,
                                                 input logic [LenW-1:0]   len);
    logic [ValueW-1:0] v;
    case (len)
      4'd1:    v = {{57{a[6]}},  a[6:0]};
      4'd2:    v = {{50{a[13]}}, a[13:0]};
      4'd3:    v = {{43{a[20]}}, a[20:0]};
      4'd4:    v = {{36{a[27]}}, a[27:0]};
      4'd5:    v = {{29{a[34]}}, a[34:0]};
      4'd6:    v = {{22{a[41]}}, a[41:0]};
      4'd7:    v = {{15{a[48]}}, a[48:0]};
      default: v = a;
    endcase
    return v;
  endfunction

endpackage

### design/pvd_stream_if.sv
`timescale 1ns / 1ps

interface pvd_byte_if;
  logic                         valid;
  logic                         ready;
  logic [pvd_pkg::ByteW-1:0]    in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface pvd_result_if;
  logic                               valid;
  logic                               ready;
  logic signed [pvd_pkg::ValueW-1:0]  value;
  logic [pvd_pkg::LenW-1:0]           encoded_length;

  modport source (output valid, output value, output encoded_length, input ready);
  modport sink   (input valid, input value, input encoded_length, output ready);
endinterface

### design/prefix_varint_decoder.sv
`timescale 1ns / 1ps

// Prefix-length varint decoder for signed 64-bit integers. One byte is taken
// per request, and a byte can be accepted in every cycle unless the input and
// result registers are both full and the result is not being taken. Each byte
// is first captured in an input register; the decode step then folds it into
// the running state and, on the last byte of a number, loads the result
// register. The input register can still take a byte while a finished result
// waits to be taken; it stalls only once it is full as well.
module prefix_varint_decoder (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  pvd_byte_if.sink             in_i,
  pvd_result_if.source         out_o
);

  logic                      in_valid_q;
  logic [pvd_pkg::ByteW-1:0] in_byte_q;
  logic                      advance;

  pvd_pkg::pvd_state_t       state_q, state_d;
  pvd_pkg::pvd_result_t      step_res;

  logic                      out_valid_q;
  logic [pvd_pkg::ValueW-1:0] value_q;
  logic [pvd_pkg::LenW-1:0]  length_q;

  // A byte that finishes a number needs a free result register; the check is
  // applied to every byte to keep the stall path short and simple.
  assign advance  = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;

  pvd_step u_step (
    .byte_i   (in_byte_q),
    .state_i  (state_q),
    .state_o  (state_d),
    .result_o (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      if (in_i.ready) begin
        in_valid_q <= in_i.valid;
      end
      if (advance) begin
        state_q <= state_d;
      end
      if (advance && step_res.done) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_byte_q <= in_i.in_byte;
    end
    if (advance && step_res.done) begin
      value_q  <= step_res.value;
      length_q <= step_res.length;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.value          = value_q;
  assign out_o.encoded_length = length_q;

  // A number never expects more than the eight bytes after a full prefix.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.bytes_left <= pvd_pkg::FullBytes)
    else $error("bytes_left out of range");

  // While a number is open, its length covers the bytes still expected.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.bytes_left != '0 |-> state_q.total_length > state_q.bytes_left)
    else $error("total_length inconsistent with bytes_left");

  // Every result reports a length from 1 to 9.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (length_q != '0) && (length_q <= pvd_pkg::LenMax))
    else $error("result length out of range");

  // A new result is loaded only when a byte leaves the input register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(in_valid_q))
    else $error("result without a consumed byte");

endmodule

### design/pvd_step.sv
`timescale 1ns / 1ps

// One byte of decode: next parser state and, on a number's last byte, its
// finished value.
module pvd_step (
  input  logic [pvd_pkg::ByteW-1:0] byte_i,
  input  pvd_pkg::pvd_state_t       state_i,
  output pvd_pkg::pvd_state_t       state_o,
  output pvd_pkg::pvd_result_t      result_o
);

  logic                      first;
  logic [pvd_pkg::LenW-1:0]  ones;
  logic [pvd_pkg::LenW-1:0]  len_first;
  logic [pvd_pkg::ByteW-1:0] mask;

  assign first     = (state_i.bytes_left == '0);
  assign ones      = pvd_pkg::lead_ones(byte_i);
  assign len_first = ones + 4'd1;
  assign mask      = 8'hFF >> len_first;

  always_comb begin
    state_o = state_i;
    if (first) begin
      if (ones >= pvd_pkg::LeadFull) begin
        state_o.accum        = '0;
        state_o.total_length = pvd_pkg::LenFull;
        state_o.bytes_left   = pvd_pkg::FullBytes;
      end else begin
        state_o.accum        = {56'd0, byte_i & mask};
        state_o.total_length = len_first;
        state_o.bytes_left   = len_first - 4'd1;
      end
    end else begin
      state_o.accum      = {state_i.accum[pvd_pkg::ValueW-pvd_pkg::ByteW-1:0], byte_i};
      state_o.bytes_left = state_i.bytes_left - 4'd1;
    end
  end

  assign result_o.done   = (state_o.bytes_left == '0);
  assign result_o.value  = pvd_pkg::sign_fix(state_o.accum, state_o.total_length);
  assign result_o.length = state_o.total_length;

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps

typedef logic [7:0] byte_q_t[$];

typedef struct {
  logic [63:0] value;
  logic [3:0]  length;
} decoded_num_t;

// Tracks the decoder state on every accepted byte and queues the number that a
// final byte completes; results from the block are checked against that queue.
class varint_scoreboard;
  logic [3:0]   left_cnt;
  logic [3:0]   num_len;
  logic [63:0]  acc;
  decoded_num_t pending_q[$];
  int           errors;
  int           results_seen;

  function new();
    left_cnt     = '0;
    num_len      = '0;
    acc          = '0;
    errors       = 0;
    results_seen = 0;
  endfunction

  function int outstanding();
    return pending_q.size();
  endfunction

  task report(string msg);
    if (errors < 30) $display("[%0t] mismatch: %s", $realtime, msg);
    errors++;
  endtask

  function void note_byte(logic [7:0] b);
    int unsigned  ones;
    int unsigned  bits;
    decoded_num_t num;
    if (left_cnt == 0) begin
      ones = 0;
      while (ones < 8 && b[7-ones]) ones++;
      if (ones >= pvd_pkg::LeadFull) begin
        acc      = '0;
        num_len  = pvd_pkg::LenFull;
        left_cnt = pvd_pkg::FullBytes;
        return;
      end
      num_len  = 4'(ones + 1);
      acc      = 64'(b & (8'hFF >> num_len));
      left_cnt = num_len - 4'd1;
    end else begin
      acc      = {acc[55:0], b};
      left_cnt = left_cnt - 4'd1;
    end
    if (left_cnt != 0) return;
    num.value  = acc;
    num.length = num_len;
    // Short codes carry 7 bits per byte and must be sign-extended to 64.
    if (num_len >= 1 && num_len <= 7) begin
      bits = 7 * num_len;
      if (acc[bits-1]) num.value = acc | (~64'd0 << bits);
    end
    pending_q.push_back(num);
  endfunction

  task check_result(logic [63:0] value, logic [3:0] length);
    decoded_num_t num;
    results_seen++;
    if (pending_q.size() == 0) begin
      report($sformatf("unexpected result value=%h length=%0d", value, length));
      return;
    end
    num = pending_q.pop_front();
    if (value !== num.value)
      report($sformatf("value %h, expected %h", value, num.value));
    if (length !== num.length)
      report($sformatf("encoded_length %0d, expected %0d", length, num.length));
  endtask
endclass

module tb_top;
  logic clk = 1'b0;
  logic rst_n;

  pvd_byte_if   byte_bus ();
  pvd_result_if res_bus ();

  prefix_varint_decoder dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (byte_bus.sink),
    .out_o  (res_bus.source)
  );

  varint_scoreboard sb = new();

  int       hold_left = 0;
  bit       hold_done = 1'b0;
  bit [8:0] stall_phase = '0;

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && byte_bus.valid && byte_bus.ready) sb.note_byte(byte_bus.in_byte);
  end

  always @(posedge clk) begin
    if (rst_n && res_bus.valid && res_bus.ready)
      sb.check_result(res_bus.value, res_bus.encoded_length);
  end

  // Receiver: rotating stall densities, plus one long hold-off once results flow.
  always @(negedge clk) begin
    if (!rst_n) begin
      res_bus.ready <= 1'b0;
    end else if (hold_left > 0) begin
      res_bus.ready <= 1'b0;
      hold_left--;
    end else if (!hold_done && sb.results_seen >= 40) begin
      hold_done = 1'b1;
      hold_left = 300;
      res_bus.ready <= 1'b0;
    end else begin
      stall_phase++;
      case (stall_phase[8:7])
        2'd0: res_bus.ready <= 1'b1;
        2'd1: res_bus.ready <= ($urandom_range(0, 3) != 0);
        2'd2: res_bus.ready <= ($urandom_range(0, 1) != 0);
        default: res_bus.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // One number with random content: lengths 1 to 7 or the 9-byte form.
  task automatic add_number(ref byte_q_t q);
    int unsigned sel;
    int unsigned len;
    int unsigned fill;
    logic [7:0]  first;
    logic [7:0]  nb;
    sel  = $urandom_range(0, 7);
    fill = $urandom_range(0, 5);
    if (sel == 7) begin
      q.push_back($urandom_range(0, 1) ? 8'hFE : 8'hFF);
      len = 9;
    end else begin
      len   = sel + 1;
      first = ~(8'hFF >> (len - 1));
      nb    = (fill == 0) ? 8'h00 : (fill == 1) ? 8'hFF : 8'($urandom);
      q.push_back(first | (nb & (8'hFF >> len)));
    end
    for (int i = 1; i < len; i++) begin
      nb = (fill == 0) ? 8'h00 : (fill == 1) ? 8'hFF : 8'($urandom);
      q.push_back(nb);
    end
  endtask

  task automatic build_random(ref byte_q_t q, input int n);
    int unsigned cnt;
    while (q.size() < n) begin
      if ($urandom_range(0, 9) == 0) begin
        // Stray bytes that throw the framing off until it realigns.
        cnt = $urandom_range(1, 3);
        repeat (cnt) q.push_back(8'($urandom));
      end else begin
        add_number(q);
      end
    end
  endtask

  // Sends a byte stream in bursts of random length with random gaps.
  task automatic send_stream(ref byte_q_t q);
    int unsigned burst;
    int unsigned gap;
    int          idx;
    idx = 0;
    while (idx < q.size()) begin
      burst = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 24);
      while (burst > 0 && idx < q.size()) begin
        @(negedge clk);
        byte_bus.valid   <= 1'b1;
        byte_bus.in_byte <= q[idx];
        do @(posedge clk); while (!byte_bus.ready);
        idx++;
        burst--;
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        byte_bus.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    byte_bus.valid <= 1'b0;
  endtask

  task automatic drain_results();
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  initial begin
    byte_q_t directed_q;
    byte_q_t rand_a_q;
    byte_q_t rand_b_q;
    byte_bus.valid   = 1'b0;
    byte_bus.in_byte = '0;
    res_bus.ready    = 1'b0;
    rst_n            = 1'b0;

    // Zero, minus one, the 2-byte extremes, and both 9-byte prefixes carrying
    // the largest and smallest 64-bit values.
    directed_q = '{8'h00, 8'h7F, 8'h9F, 8'hFF, 8'hA0, 8'h00,
                   8'hFE, 8'h7F, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                   8'hFF, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    build_random(rand_a_q, 650);
    build_random(rand_b_q, 650);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_stream(directed_q);
    drain_results();
    send_stream(rand_a_q);
    drain_results();
    send_stream(rand_b_q);
    drain_results();
    repeat (10) @(posedge clk);

    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
